// ----- hw/rtl/loie_pkg.sv -----
// Shared types, codes and defaults for the log offset index engine.
// No dependencies; used by loie_table, loie_seq and the top level.
package loie_pkg;

	localparam int DEF_INDEX_DEPTH  = 1024;
	localparam int DEF_HEADER_BYTES = 24;

	localparam int OFFSET_W   = 64;
	localparam int POS_W      = 40;
	localparam int LEN_W      = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [POS_W-1:0] MAX_SEG_RESET = 40'd1073741824;

	// operation codes
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFF = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG   = 8'd1;

	typedef struct packed {
		logic                operation;
		logic [LEN_W-1:0]    payload_len;
		logic [OFFSET_W-1:0] lookup_off;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] record_offset;
		logic [POS_W-1:0]    byte_position;
	} result_t;

endpackage

// ----- hw/rtl/loie_table.sv -----
// Index table memory: one write port, one read port with registered data.
// Depends on loie_pkg for the entry widths.
module loie_table #(
	parameter int DEPTH = loie_pkg::DEF_INDEX_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [loie_pkg::OFFSET_W-1:0] wr_offset,
	input  logic [loie_pkg::POS_W-1:0]    wr_position,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [loie_pkg::OFFSET_W-1:0] rd_offset,
	output logic [loie_pkg::POS_W-1:0]    rd_position
);

	logic [loie_pkg::OFFSET_W-1:0] off_mem [DEPTH];
	logic [loie_pkg::POS_W-1:0]    pos_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			off_mem[wr_addr] <= wr_offset;
			pos_mem[wr_addr] <= wr_position;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_offset   <= off_mem[rd_addr];
			rd_position <= pos_mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/loie_seq.sv -----
// Sequencer: segment state, append path and the binary search loop that
// reuses one 64-bit key compare per probe. Depends on loie_pkg.
module loie_seq #(
	parameter int INDEX_DEPTH  = loie_pkg::DEF_INDEX_DEPTH,
	parameter int HEADER_BYTES = loie_pkg::DEF_HEADER_BYTES,
	localparam int AW = $clog2(INDEX_DEPTH),
	localparam int CW = $clog2(INDEX_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  loie_pkg::req_t                req,
	output logic                          res_valid,
	input  logic                          res_take,
	output loie_pkg::result_t             res,
	input  logic                          base_load,
	input  logic [loie_pkg::OFFSET_W-1:0] base_value,
	input  logic [loie_pkg::POS_W-1:0]    max_seg_bytes,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [loie_pkg::OFFSET_W-1:0] wr_offset,
	output logic [loie_pkg::POS_W-1:0]    wr_position,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [loie_pkg::OFFSET_W-1:0] rd_offset,
	input  logic [loie_pkg::POS_W-1:0]    rd_position
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_APPEND = 3'd1;
	localparam logic [2:0] ST_PROBE  = 3'd2;
	localparam logic [2:0] ST_DONE   = 3'd3;

	localparam int PW = loie_pkg::POS_W;

	logic [2:0]                    state_q;
	loie_pkg::req_t                req_q;
	loie_pkg::result_t             res_q;
	logic [PW-1:0]                 seg_q;
	logic [loie_pkg::OFFSET_W-1:0] next_off_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 lo_q;
	logic [CW-1:0]                 hi_q;
	logic [CW-1:0]                 mid_q;

	logic          accept;
	logic          key_gt, key_lt, key_eq;
	logic [CW-1:0] cand_lo, cand_hi, cand_mid;
	logic          cand_open;
	logic          full;
	logic [PW:0]   grown;
	logic [PW-1:0] seg_next;

	// lower middle of [lo, hi), lo < hi
	function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
		logic [CW-1:0] span;
		span = hi - lo - CW'(1);
		return lo + (span >> 1);
	endfunction

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// shared key compare
	always_comb begin
		key_gt = req_q.lookup_off > rd_offset;
		key_lt = req_q.lookup_off < rd_offset;
		key_eq = !key_gt && !key_lt;
	end

	// next search window: from the entry count on a new lookup, else narrowed
	always_comb begin
		if (state_q == ST_IDLE) begin
			cand_lo = '0;
			cand_hi = count_q;
		end else begin
			cand_lo = key_gt ? mid_q + CW'(1) : lo_q;
			cand_hi = key_lt ? mid_q : hi_q;
		end
		cand_open = cand_lo < cand_hi;
		cand_mid  = mid_of(cand_lo, cand_hi);
	end

	assign rd_en = (accept && req.operation == loie_pkg::OP_LOOKUP && cand_open)
		|| (state_q == ST_PROBE && !key_eq && cand_open);
	assign rd_addr = cand_mid[AW-1:0];

	// append path, saturating size
	always_comb begin
		full     = (seg_q >= max_seg_bytes) || (count_q >= CW'(INDEX_DEPTH));
		grown    = {1'b0, seg_q} + (PW+1)'(HEADER_BYTES)
			+ {{(PW+1-loie_pkg::LEN_W){1'b0}}, req_q.payload_len};
		seg_next = grown[PW] ? {PW{1'b1}} : grown[PW-1:0];
	end

	assign wr_en       = (state_q == ST_APPEND) && !full;
	assign wr_addr     = count_q[AW-1:0];
	assign wr_offset   = next_off_q;
	assign wr_position = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seg_q      <= '0;
			next_off_q <= '0;
			count_q    <= '0;
		end else begin
			if (base_load && count_q == '0) begin
				next_off_q <= base_value;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q <= req;
						if (req.operation == loie_pkg::OP_APPEND) begin
							state_q <= ST_APPEND;
						end else if (cand_open) begin
							lo_q    <= cand_lo;
							hi_q    <= cand_hi;
							mid_q   <= cand_mid;
							state_q <= ST_PROBE;
						end else begin
							res_q   <= '{loie_pkg::STATUS_NOT_FOUND, req.lookup_off, '0};
							state_q <= ST_DONE;
						end
					end
				end
				ST_APPEND: begin
					if (full) begin
						res_q <= '{loie_pkg::STATUS_FULL, next_off_q, seg_q};
					end else begin
						res_q      <= '{loie_pkg::STATUS_OK, next_off_q, seg_q};
						seg_q      <= seg_next;
						next_off_q <= next_off_q + 64'd1;
						count_q    <= count_q + CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_PROBE: begin
					if (key_eq) begin
						res_q   <= '{loie_pkg::STATUS_OK, req_q.lookup_off, rd_position};
						state_q <= ST_DONE;
					end else if (cand_open) begin
						lo_q  <= cand_lo;
						hi_q  <= cand_hi;
						mid_q <= cand_mid;
					end else begin
						res_q   <= '{loie_pkg::STATUS_NOT_FOUND, req_q.lookup_off, '0};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/log_offset_index_engine_top.sv -----
// Top level of the log offset index engine: stream ports, config port,
// output register. Depends on loie_pkg, loie_table and loie_seq.
//
//  - Slave stream (s_*): one beat is one command. s_tuser[0] selects append
//    (0) or lookup (1); s_tdata carries the payload length and lookup offset.
//  - Master stream (m_*): one result beat per command; m_tuser is the status
//    (ok, full, not found), m_tdata the record offset and byte position.
//  - Config port (cfg_*): always ready. Index 0 writes the start offset,
//    which loads the next offset only while the index is empty; index 1 writes
//    max_segment_bytes; other indexes are dropped. Write only while idle.
//  - Sequence: an append goes from accept through the append state to the
//    done state, where its result is valid. A lookup makes P table probes,
//    where P is at most clog2(entries + 1), so 11 for a full 1024-entry
//    table; one probe per cycle, set by the single table read port and
//    the shared key compare feeding it.
//  - s_tready is high only while no command is in progress. A result
//    waiting in the output register does not block a new command; only
//    the hand-over of the next result waits for m_tready.
//  - Reset clears the index (empty, size zero, next offset zero) and sets
//    max_segment_bytes to 2^30. No clearing pass is needed.
module log_offset_index_engine_top #(
	parameter int INDEX_DEPTH  = loie_pkg::DEF_INDEX_DEPTH,
	parameter int HEADER_BYTES = loie_pkg::DEF_HEADER_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [95:0]                     s_tdata,  // payload_len[31:0], lookup_off[95:32]
	input  logic [0:0]                      s_tuser,  // operation[0]
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [103:0]                    m_tdata,  // record_offset[63:0], byte_position[103:64]
	output logic [1:0]                      m_tuser,  // status[1:0]
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [loie_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [loie_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(INDEX_DEPTH);

	loie_pkg::req_t    req;
	loie_pkg::result_t seq_res;
	loie_pkg::result_t out_q;
	logic              m_tvalid_q;
	logic              seq_res_valid;
	logic              res_take;
	logic              cfg_fire;
	logic              base_load;
	logic [loie_pkg::POS_W-1:0] max_seg_q;

	logic                          wr_en, rd_en;
	logic [AW-1:0]                 wr_addr, rd_addr;
	logic [loie_pkg::OFFSET_W-1:0] wr_offset, rd_offset;
	logic [loie_pkg::POS_W-1:0]    wr_position, rd_position;

	// unpack command beat
	assign req.operation   = s_tuser[0];
	assign req.payload_len = s_tdata[31:0];
	assign req.lookup_off  = s_tdata[95:32];

	// config: the start offset only matters as the next offset of an empty
	// index, so it goes straight to the sequencer
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign base_load = cfg_fire && (cfg_index == loie_pkg::CFG_START_OFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seg_q <= loie_pkg::MAX_SEG_RESET;
		end else if (cfg_fire) begin
			case (cfg_index)
				loie_pkg::CFG_MAX_SEG: begin
					max_seg_q <= cfg_data[loie_pkg::POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// output register: free when empty or its beat leaves this cycle
	assign res_take = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= seq_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && seq_res_valid) begin
			out_q <= seq_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.byte_position, out_q.record_offset};
	assign m_tuser  = out_q.status;

	loie_seq #(
		.INDEX_DEPTH (INDEX_DEPTH),
		.HEADER_BYTES(HEADER_BYTES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (s_tvalid),
		.req_ready    (s_tready),
		.req          (req),
		.res_valid    (seq_res_valid),
		.res_take     (res_take),
		.res          (seq_res),
		.base_load    (base_load),
		.base_value   (cfg_data),
		.max_seg_bytes(max_seg_q),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_offset    (wr_offset),
		.wr_position  (wr_position),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_offset    (rd_offset),
		.rd_position  (rd_position)
	);

	loie_table #(
		.DEPTH(INDEX_DEPTH)
	) u_table (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_offset  (wr_offset),
		.wr_position(wr_position),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_offset  (rd_offset),
		.rd_position(rd_position)
	);

endmodule
